### hw/rtl/lr_pkg.sv
package lr_pkg;

    // Fixed field widths
    localparam int COORD_W = 6;
    localparam int COUNT_W = COORD_W + 1;
    localparam int COLOR_W = 24;
    localparam int REG_W   = 7;
    localparam int INDEX_W = 2;

    // Defaults for the top-level parameters
    localparam int TILE_SIZE_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Register reset values
    localparam logic [REG_W-1:0] IMAGE_WIDTH_RST  = 7'd64;
    localparam logic [REG_W-1:0] IMAGE_HEIGHT_RST = 7'd64;

    // One classified line, as it travels from front to back
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COUNT_W-1:0] major;
        logic [COUNT_W-1:0] minor;
        logic               y_major;
        logic               x_down;
        logic               y_down;
        logic [COLOR_W-1:0] color;
    } t_line;

endpackage

### hw/rtl/lr_front.sv
module lr_front #(
    parameter int TILE_SIZE = lr_pkg::TILE_SIZE_DEF
) (
    input  logic [lr_pkg::COORD_W-1:0] i_start_x,
    input  logic [lr_pkg::COORD_W-1:0] i_start_y,
    input  logic [lr_pkg::COORD_W-1:0] i_end_x,
    input  logic [lr_pkg::COORD_W-1:0] i_end_y,
    input  logic [lr_pkg::COLOR_W-1:0] i_line_color,
    output lr_pkg::t_line              o_line
);
    import lr_pkg::*;

    localparam logic [COORD_W-1:0] MaxCoord = COORD_W'(TILE_SIZE - 1);

    logic [COORD_W-1:0] x0, y0, x1, y1;
    logic [COUNT_W-1:0] nx, ny;
    logic               y_major;

    // Saturate endpoints to the tile
    assign x0 = (i_start_x > MaxCoord) ? MaxCoord : i_start_x;
    assign y0 = (i_start_y > MaxCoord) ? MaxCoord : i_start_y;
    assign x1 = (i_end_x > MaxCoord) ? MaxCoord : i_end_x;
    assign y1 = (i_end_y > MaxCoord) ? MaxCoord : i_end_y;

    // Pixel counts along each axis
    assign nx = (x0 > x1) ? (COUNT_W'(x0 - x1) + COUNT_W'(1))
                          : (COUNT_W'(x1 - x0) + COUNT_W'(1));
    assign ny = (y0 > y1) ? (COUNT_W'(y0 - y1) + COUNT_W'(1))
                          : (COUNT_W'(y1 - y0) + COUNT_W'(1));

    // Pick the major axis, ties go to x
    assign y_major = ny > nx;

    always_comb begin
        o_line.x0      = x0;
        o_line.y0      = y0;
        o_line.major   = y_major ? ny : nx;
        o_line.minor   = y_major ? nx : ny;
        o_line.y_major = y_major;
        o_line.x_down  = x0 > x1;
        o_line.y_down  = y0 > y1;
        o_line.color   = i_line_color;
    end

endmodule

### hw/rtl/lr_queue.sv
module lr_queue #(
    parameter int DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lr_pkg::t_line i_line,
    input  logic          i_pop,
    output lr_pkg::t_line o_line,
    output logic          o_valid,
    output logic          o_full
);
    import lr_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_line           r_mem [DEPTH];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_count;
    logic            push_ok, pop_ok;

    assign o_full  = r_count == FullCnt;
    assign o_valid = r_count != '0;
    assign o_line  = r_mem[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // Store a beat at the write pointer
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_line;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == LastPtr) ? '0 : r_wptr + PtrW'(1);
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == LastPtr) ? '0 : r_rptr + PtrW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CntW'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

### hw/rtl/lr_back.sv
module lr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lr_pkg::t_line              i_line,
    input  logic                       i_line_valid,
    output logic                       o_line_pop,
    input  logic [lr_pkg::REG_W-1:0]   i_image_width,
    input  logic [lr_pkg::REG_W-1:0]   i_image_height,
    output logic                       o_strobe,
    output logic [lr_pkg::COORD_W-1:0] o_pixel_x,
    output logic [lr_pkg::COORD_W-1:0] o_pixel_y,
    output logic [lr_pkg::COLOR_W-1:0] o_pixel_color,
    output logic                       o_inside_res,
    output logic                       o_last
);
    import lr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [COORD_W-1:0] r_x, r_y;
    logic [COUNT_W-1:0] r_acc, r_rem, r_major, r_minor;
    logic               r_y_major, r_x_down, r_y_down;
    logic [COLOR_W-1:0] r_color;

    logic               r_strobe;
    logic [COORD_W-1:0] r_pixel_x, r_pixel_y;
    logic [COLOR_W-1:0] r_pixel_color;
    logic               r_inside, r_last;

    logic [COUNT_W:0]   acc_sum;
    logic               minor_step, is_last, emit, load;
    logic               x_step, y_step;

    // Error accumulator: add the minor count, wrap at the major count
    assign acc_sum    = {1'b0, r_acc} + {1'b0, r_minor};
    assign minor_step = acc_sum >= {1'b0, r_major};
    assign is_last    = r_rem == COUNT_W'(1);
    assign x_step     = r_y_major ? minor_step : 1'b1;
    assign y_step     = r_y_major ? 1'b1 : minor_step;

    // Sequence lines: take a new one when idle or right after the last pixel
    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_line_valid) begin
                    load    = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                emit = 1'b1;
                if (is_last) begin
                    if (i_line_valid) begin
                        load = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_line_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= emit;
        end
    end

    // Walk the line one pixel per cycle
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x       <= i_line.x0;
            r_y       <= i_line.y0;
            r_acc     <= '0;
            r_rem     <= i_line.major;
            r_major   <= i_line.major;
            r_minor   <= i_line.minor;
            r_y_major <= i_line.y_major;
            r_x_down  <= i_line.x_down;
            r_y_down  <= i_line.y_down;
            r_color   <= i_line.color;
        end else if (emit) begin
            r_acc <= minor_step ? COUNT_W'(acc_sum - {1'b0, r_major})
                                : COUNT_W'(acc_sum);
            r_rem <= r_rem - COUNT_W'(1);
            if (x_step) begin
                r_x <= r_x_down ? r_x - COORD_W'(1) : r_x + COORD_W'(1);
            end
            if (y_step) begin
                r_y <= r_y_down ? r_y - COORD_W'(1) : r_y + COORD_W'(1);
            end
        end
    end

    // Register the pixel beat
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pixel_x     <= r_x;
            r_pixel_y     <= r_y;
            r_pixel_color <= r_color;
            r_inside      <= ({1'b0, r_x} < i_image_width) &&
                             ({1'b0, r_y} < i_image_height);
            r_last        <= is_last;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_pixel_x     = r_pixel_x;
    assign o_pixel_y     = r_pixel_y;
    assign o_pixel_color = r_pixel_color;
    assign o_inside_res  = r_inside;
    assign o_last        = r_last;

endmodule

### hw/rtl/line_rasterizer.sv
// Channel    Direction  Handshake             Payload
// line       in         start & !busy         i_start_x/y, i_end_x/y, i_line_color
// pixel      out        o_strobe, one cycle   o_pixel_x/y, o_pixel_color, o_inside_res, o_last
// config     in         i_cfg_we              i_cfg_index, i_cfg_data
//
// A line of N pixels (N = larger axis count, 1 to TILE_SIZE) is walked one pixel beat per
// cycle; an accepted line is queued, then loaded into the stepping unit; each beat is registered.
// Lines waiting in the queue follow the previous last pixel with no gap.
// busy rises while the line queue is full. Reset is synchronous, active low; it
// empties the queue and sets both image sizes to 64. The pixel side never stalls.
module line_rasterizer #(
    parameter int TILE_SIZE   = lr_pkg::TILE_SIZE_DEF,
    parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [lr_pkg::COORD_W-1:0] i_start_x,
    input  logic [lr_pkg::COORD_W-1:0] i_start_y,
    input  logic [lr_pkg::COORD_W-1:0] i_end_x,
    input  logic [lr_pkg::COORD_W-1:0] i_end_y,
    input  logic [lr_pkg::COLOR_W-1:0] i_line_color,
    input  logic                       i_cfg_we,
    input  logic [lr_pkg::INDEX_W-1:0] i_cfg_index,
    input  logic [lr_pkg::REG_W-1:0]   i_cfg_data,
    output logic                       o_strobe,
    output logic [lr_pkg::COORD_W-1:0] o_pixel_x,
    output logic [lr_pkg::COORD_W-1:0] o_pixel_y,
    output logic [lr_pkg::COLOR_W-1:0] o_pixel_color,
    output logic                       o_inside_res,
    output logic                       o_last
);
    import lr_pkg::*;

    logic [REG_W-1:0] r_image_width, r_image_height;
    t_line            front_line, q_line;
    logic             q_valid, q_full, q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = q_full;

    lr_front #(
        .TILE_SIZE (TILE_SIZE)
    ) u_front (
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_line_color (i_line_color),
        .o_line       (front_line)
    );

    lr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_line  (front_line),
        .i_pop   (q_pop),
        .o_line  (q_line),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    lr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_line         (q_line),
        .i_line_valid   (q_valid),
        .o_line_pop     (q_pop),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_strobe       (o_strobe),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_inside_res   (o_inside_res),
        .o_last         (o_last)
    );

endmodule
